// File: src/grid_menu_selection_debouncer_assert.svh
// Assertion macros for the grid menu selection debouncer.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef GRID_MENU_SELECTION_DEBOUNCER_ASSERT_SVH
`define GRID_MENU_SELECTION_DEBOUNCER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GMSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define GMSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/gmsd_pkg.sv
// Shared types and constants for the grid menu selection debouncer.
// No dependencies; imported by the slot unit and the top level.
`default_nettype none

package gmsd_pkg;

  localparam int CNT_W    = 8;
  localparam int SQ_W     = 6;
  localparam int ID_W     = 8;
  localparam int ITEM_W   = 3;
  localparam int ROW_W    = 3;
  localparam int COLS     = 8;
  localparam logic [ROW_W-1:0] ROW_MAX = 3'd7;

  localparam int OCC_W    = COLS * COLS;
  localparam int ISQ_W    = 48;
  localparam int IID_W    = 64;
  localparam int ICNT_W   = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;
  localparam int OUT_W    = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STABLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_SQUARES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_IDS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_ROWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_ENABLED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_SQUARE  = 3'd6;

  typedef enum logic [1:0] {
    OUT_NONE = 2'd0,
    OUT_ITEM = 2'd1,
    OUT_BACK = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } seq_state_t;

  typedef struct packed {
    logic [CNT_W-1:0] empty_ticks;
    logic [CNT_W-1:0] occupied_ticks;
    logic             armed;
    logic             fired_latch;
  } slot_state_t;

endpackage

`default_nettype wire

// File: src/gmsd_slot_unit.sv
// Shared debouncer update unit: advances one slot's counters and flags.
// Depends on gmsd_pkg for the slot state struct.
`default_nettype none

module gmsd_slot_unit (
  input  wire                          occ,
  input  wire  [gmsd_pkg::CNT_W-1:0]   limit,
  input  gmsd_pkg::slot_state_t        cur,
  output gmsd_pkg::slot_state_t        upd,
  output logic                         fire
);
  import gmsd_pkg::*;

  logic [CNT_W-1:0] empty_inc;
  logic [CNT_W-1:0] occ_inc;

  assign empty_inc = (cur.empty_ticks < limit) ? cur.empty_ticks + 1'b1 : cur.empty_ticks;
  assign occ_inc   = (cur.occupied_ticks < limit) ? cur.occupied_ticks + 1'b1
                                                  : cur.occupied_ticks;

  always_comb begin
    upd  = cur;
    fire = 1'b0;
    if (!occ) begin
      upd.empty_ticks    = empty_inc;
      upd.occupied_ticks = '0;
      upd.fired_latch    = 1'b0;
      if (empty_inc >= limit) begin
        upd.armed = 1'b1;
      end
    end else begin
      upd.empty_ticks = '0;
      if (!cur.armed || cur.fired_latch) begin
        upd.occupied_ticks = '0;
      end else begin
        upd.occupied_ticks = occ_inc;
        if (occ_inc >= limit) begin
          upd.armed       = 1'b0;
          upd.fired_latch = 1'b1;
          fire            = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: src/grid_menu_selection_debouncer.sv
// Top level of the grid menu selection debouncer: config registers, slot state,
// scan sequencer and output register. Depends on gmsd_pkg and gmsd_slot_unit.
//
//   channel   direction  handshake                  payload
//   s_axis    in         s_axis_tvalid/tready       tdata[63:0] occupancy
//   m_axis    out        m_axis_tvalid/tready       tdata[15:0] outcome, item_id, square
//   cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// A word is handled in steps: it is taken in the idle state, the item slots in use
// (n of them) are scanned in order until one fires, the scan at slot n is spent on
// the back check whether or not it is enabled, and the result is then handed over
// to the output register. Reset clears all slot state at once. A new word
// is taken while a result still waits in the output register; a stalled output
// holds the finished result in the sequencer until the register frees up.
`default_nettype none

module grid_menu_selection_debouncer #(
  parameter int MAX_SLOTS = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [gmsd_pkg::OCC_W-1:0]       s_axis_tdata,   // [63:0] occupancy
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [gmsd_pkg::OUT_W-1:0]       m_axis_tdata,   // [1:0] outcome,
                                                           // [9:2] item_id,
                                                           // [15:10] chosen_square
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [gmsd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [gmsd_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import gmsd_pkg::*;

  localparam int DEPTH = MAX_SLOTS + 1;
  localparam int SW    = $clog2(DEPTH);

  // Configuration registers.
  logic [CNT_W-1:0]  stable_count;
  logic [ICNT_W-1:0] item_count;
  logic [ISQ_W-1:0]  item_squares;
  logic [IID_W-1:0]  item_ids;
  logic              flip_rows;
  logic              back_enabled;
  logic [SQ_W-1:0]   back_square;

  slot_state_t slots [DEPTH];

  seq_state_t state, state_next;
  logic [SW-1:0]    scan_k, scan_k_next;
  logic [OCC_W-1:0] occ_word;

  outcome_t         res_outcome, res_outcome_next;
  logic [ID_W-1:0]  res_id, res_id_next;
  logic [SQ_W-1:0]  res_sq, res_sq_next;

  logic [CNT_W-1:0] limit;
  logic [SW-1:0]    n_eff;
  logic [ITEM_W-1:0] item_idx;
  logic [SQ_W-1:0]  raw_sq, map_sq;
  logic             is_item, is_back, active;
  slot_state_t      unit_upd;
  logic             unit_fire, slot_fire, load_out, in_accept;
  logic             out_none;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count <= CNT_W'(1);
      item_count   <= '0;
      item_squares <= '0;
      item_ids     <= '0;
      flip_rows    <= 1'b0;
      back_enabled <= 1'b0;
      back_square  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_STABLE_COUNT: stable_count <= cfg_data[CNT_W-1:0];
        REG_ITEM_COUNT:   item_count   <= cfg_data[ICNT_W-1:0];
        REG_ITEM_SQUARES: item_squares <= cfg_data[ISQ_W-1:0];
        REG_ITEM_IDS:     item_ids     <= cfg_data[IID_W-1:0];
        REG_FLIP_ROWS:    flip_rows    <= cfg_data[0];
        REG_BACK_ENABLED: back_enabled <= cfg_data[0];
        REG_BACK_SQUARE:  back_square  <= cfg_data[SQ_W-1:0];
        default: ;
      endcase
    end
  end

  // A stable count of zero behaves as one; item counts saturate at the slot count.
  assign limit = (stable_count == '0) ? CNT_W'(1) : stable_count;
  assign n_eff = (item_count > ICNT_W'(MAX_SLOTS)) ? SW'(MAX_SLOTS) : SW'(item_count);

  assign is_item  = (scan_k < n_eff);
  assign is_back  = (scan_k == n_eff) && back_enabled;
  assign active   = is_item || is_back;
  assign item_idx = ITEM_W'(scan_k);
  assign raw_sq   = is_item ? item_squares[item_idx * SQ_W +: SQ_W] : back_square;
  assign map_sq   = {flip_rows ? (ROW_MAX - raw_sq[SQ_W-1 -: ROW_W]) : raw_sq[SQ_W-1 -: ROW_W],
                     raw_sq[SQ_W-ROW_W-1:0]};

  gmsd_slot_unit u_slot (
    .occ   (occ_word[map_sq]),
    .limit (limit),
    .cur   (slots[scan_k]),
    .upd   (unit_upd),
    .fire  (unit_fire)
  );

  assign slot_fire = (state == ST_SCAN) && active && unit_fire;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign load_out  = (state == ST_HOLD) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    state_next       = state;
    scan_k_next      = scan_k;
    res_outcome_next = res_outcome;
    res_id_next      = res_id;
    res_sq_next      = res_sq;
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          state_next  = ST_SCAN;
          scan_k_next = '0;
        end
      end
      ST_SCAN: begin
        if (slot_fire) begin
          res_outcome_next = is_item ? OUT_ITEM : OUT_BACK;
          res_id_next      = is_item ? item_ids[item_idx * ID_W +: ID_W] : '0;
          res_sq_next      = map_sq;
          state_next       = ST_HOLD;
        end else if (!is_item) begin
          res_outcome_next = OUT_NONE;
          res_id_next      = '0;
          res_sq_next      = '0;
          state_next       = ST_HOLD;
        end else begin
          scan_k_next = SW'(scan_k + 1'b1);
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      scan_k <= '0;
    end else begin
      state  <= state_next;
      scan_k <= scan_k_next;
    end
  end

  always_ff @(posedge clk) begin
    res_outcome <= res_outcome_next;
    res_id      <= res_id_next;
    res_sq      <= res_sq_next;
    if (in_accept) begin
      occ_word <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        slots[i] <= '0;
      end
    end else if ((state == ST_SCAN) && active) begin
      slots[scan_k] <= unit_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load_out) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_axis_tdata <= {res_sq, res_id, res_outcome};
    end
  end

  assign out_none = m_axis_tvalid && (m_axis_tdata[1:0] == OUT_NONE);

`include "grid_menu_selection_debouncer_assert.svh"

  `GMSD_ASSERT_NEXT(a_accept_starts_scan, in_accept, state == ST_SCAN, "accept did not scan")
  `GMSD_ASSERT_NOW(a_scan_in_range, state == ST_SCAN, scan_k <= n_eff, "scan past last slot")
  `GMSD_ASSERT_NOW(a_none_is_zero, out_none, m_axis_tdata[15:2] == '0, "empty result has data")

endmodule

`default_nettype wire
